// ===== rtl/mi4_pkg.sv =====
`timescale 1ns / 1ps
// mi4_pkg: shared widths, word types and cofactor helper functions for the
// 4x4 matrix inverse unit. No dependencies.
package mi4_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IDX_W         = 4;
  localparam int VAL_W         = 32;
  localparam int DET_W         = 64;
  localparam int LIMB_W        = 32;
  localparam int COF_W         = 98;   // signed cofactor, sum of six triple products
  localparam int ACC_W         = 130;  // signed determinant, four cofactor products
  localparam int X_W           = 128;  // multiplicand, four limbs
  localparam int QUEUE_DEPTH   = 4;
  localparam int IN_DATA_W     = 40;
  localparam int OUT_DATA_W    = 104;
  localparam int OUT_USER_W    = 2;

  localparam logic [1:0] MODE_INV = 2'd0;
  localparam logic [1:0] MODE_ADJ = 2'd1;
  localparam logic [1:0] MODE_DET = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic             go;
  } mi4_item_t;

  // column picked by permutation p for minor row i
  function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] i);
    logic [5:0] cols;
    case (p)
      3'd0: cols = {2'd2, 2'd1, 2'd0};
      3'd1: cols = {2'd1, 2'd2, 2'd0};
      3'd2: cols = {2'd2, 2'd0, 2'd1};
      3'd3: cols = {2'd0, 2'd2, 2'd1};
      3'd4: cols = {2'd1, 2'd0, 2'd2};
      3'd5: cols = {2'd0, 2'd1, 2'd2};
      default: cols = {2'd2, 2'd1, 2'd0};
    endcase
    case (i)
      2'd0: perm_col = cols[1:0];
      2'd1: perm_col = cols[3:2];
      default: perm_col = cols[5:4];
    endcase
  endfunction

  function automatic logic perm_odd(input logic [2:0] p);
    perm_odd = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
  endfunction

  // minor index i mapped past the removed row or column
  function automatic logic [1:0] skip(input logic [1:0] i, input logic [1:0] excl);
    skip = (i < excl) ? i : i + 2'd1;
  endfunction

endpackage

// ===== rtl/matrix_inverse_4x4_unit.sv =====
`timescale 1ns / 1ps
// 4x4 matrix inverse/adjugate/determinant by cofactors, Q(32-F).F elements.
// Load words: one per cycle into a 4-deep queue unless full. A tlast word starts a run:
// the determinant from four cofactors on a shared 33x32 multiplier (sole output in det
// modes), then per element the cofactor (adjugate) or bit-serial cofactor/det (inverse).
// Reset (rst_n low, synchronous) clears the element store, queue, mode and output valid.
module matrix_inverse_4x4_unit
  import mi4_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // element_index[3:0], element_value[35:4], 0
  input  logic                  in_tlast,   // go
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_row[1:0], out_column[3:2],
                                            // out_value[35:4], determinant[99:36], 0
  output logic [OUT_USER_W-1:0] out_tuser,  // singular[0], saturated[1]
  output logic                  out_tlast,  // last_result
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_wr_data // result_mode
);

  logic [1:0] mode_r;
  mi4_item_t  in_item, q_item;
  logic       q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INV;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  assign in_item.idx   = in_tdata[IDX_W-1:0];
  assign in_item.value = in_tdata[IDX_W+VAL_W-1:IDX_W];
  assign in_item.go    = in_tlast;

  mi4_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  mi4_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .mode       (mode_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_sing_det_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[99:36] == '0)
    else $error("singular result with nonzero determinant");

  a_sing_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && mode_r == MODE_INV |-> out_tdata[35:4] == '0)
    else $error("singular inverse element not zero");

  a_det_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && mode_r[1] |-> out_tlast && out_tdata[35:0] == '0)
    else $error("determinant-only result malformed");

  a_reset_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule

// ===== rtl/mi4_front.sv =====
`timescale 1ns / 1ps
// mi4_front: input queue that decouples word acceptance from the compute back end.
// Depends on mi4_pkg.
module mi4_front
  import mi4_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mi4_item_t in_item,
  input  logic      q_pop,
  output logic      q_valid,
  output mi4_item_t q_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mi4_item_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              push, pop;

  assign in_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== rtl/mi4_div.sv =====
`timescale 1ns / 1ps
// mi4_div: bit-serial restoring divider of magnitudes, one quotient bit per cycle,
// signed result saturated to 32 bits. Depends on mi4_pkg.
module mi4_div
  import mi4_pkg::*;
#(
  parameter int NUM_W = 130,
  parameter int DEN_W = ACC_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic             neg,
  output logic             done,
  output logic [VAL_W-1:0] quo,
  output logic             sat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, done_r, neg_r, big_r, sat_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r, rem_r;
  logic [VAL_W:0]   q_r;
  logic [VAL_W-1:0] quo_r;
  logic [DEN_W:0]   rem_sh, diff;
  logic             ge, over;
  logic [VAL_W:0]   limit;

  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = (rem_sh >= {1'b0, den_r});
  assign limit  = neg_r ? {2'b01, {(VAL_W-1){1'b0}}} : {2'b00, {(VAL_W-1){1'b1}}};
  assign over   = big_r || (q_r > limit);

  assign done = done_r;
  assign quo  = quo_r;
  assign sat  = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= num;
        den_r  <= den;
        neg_r  <= neg;
        rem_r  <= '0;
        q_r    <= '0;
        big_r  <= 1'b0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(NUM_W)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          sat_r  <= over;
          quo_r  <= over ? limit[VAL_W-1:0]
                         : (neg_r ? (VAL_W'(0) - q_r[VAL_W-1:0]) : q_r[VAL_W-1:0]);
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
          num_r <= {num_r[NUM_W-2:0], 1'b0};
          rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          q_r   <= {q_r[VAL_W-1:0], ge};
          big_r <= big_r | q_r[VAL_W];
        end
      end
    end
  end

endmodule

// ===== rtl/mi4_back.sv =====
`timescale 1ns / 1ps
// mi4_back: element store, cofactor/determinant sequencer on a shared 33x32
// multiplier, output register. Depends on mi4_pkg and mi4_div.
module mi4_back
  import mi4_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  mi4_item_t             q_item,
  output logic                  q_pop,
  input  logic [1:0]            mode,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  localparam int DSH    = 4 * FRAC_BITS - 32;
  localparam int ADJ_SH = 2 * FRAC_BITS;
  localparam int NUM_W  = COF_W + ADJ_SH;

  typedef enum logic [3:0] {
    S_IDLE, S_CSTART, S_RA, S_RB, S_RC, S_MUL, S_ADD,
    S_CDONE, S_DFIN, S_VAL, S_DIV, S_EMIT
  } state_t;

  state_t            state_r;
  logic [VAL_W-1:0]  store_r [16];
  logic [1:0]        tr_r, tc_r, li_r, last_r;
  logic [2:0]        p_r;
  logic [3:0]        k_r;
  logic              to_det_r, neg_r, pass2_r;
  logic [VAL_W-1:0]  rd_r, opa_r, val_r;
  logic [X_W-1:0]    x_r;
  logic signed [64:0] ml_r;
  logic [ACC_W-1:0]  cof_r, det_r, absd_r;
  logic [DET_W-1:0]  det_bits_r;
  logic              det_sat_r, sing_r, dneg_r, vsat_r;
  logic              out_valid_r, out_last_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic [1:0]        step, rs, cs;
  logic [3:0]        rd_addr;
  logic [LIMB_W-1:0] limb;
  logic [LIMB_W:0]   limb_ext;
  logic signed [64:0] ml_nxt;
  logic signed [63:0] prod;
  logic [ACC_W-1:0]  ml_wide, addend, tgt, sum;
  logic signed [ACC_W-1:0] dv, av;
  logic [ACC_W-64:0] dhi;
  logic [ACC_W-32:0] ahi;
  logic              dfit, afit, cneg, emit_ok;
  logic [ACC_W-1:0]  cmag;
  logic [NUM_W-1:0]  num;
  logic              div_start, div_done, div_sat;
  logic [VAL_W-1:0]  div_quo;
  logic [3:0]        k_inc;

  always_comb begin
    case (state_r)
      S_RA:    step = 2'd0;
      S_RB:    step = 2'd1;
      default: step = 2'd2;
    endcase
  end

  assign rs       = skip(step, tr_r);
  assign cs       = skip(perm_col(p_r, step), tc_r);
  assign rd_addr  = (state_r == S_CDONE) ? {tc_r, 2'b00} : {cs, rs};
  assign limb     = x_r[32*li_r +: LIMB_W];
  assign limb_ext = {(li_r == last_r) & limb[LIMB_W-1], limb};
  assign ml_nxt   = $signed(limb_ext) * $signed(rd_r);
  assign prod     = $signed(opa_r) * $signed(rd_r);
  assign ml_wide  = {{(ACC_W-65){ml_r[64]}}, ml_r};
  assign addend   = ml_wide << {li_r, 5'd0};
  assign tgt      = to_det_r ? det_r : cof_r;
  assign sum      = neg_r ? (tgt - addend) : (tgt + addend);

  assign dv   = $signed(det_r) >>> DSH;
  assign dhi  = dv[ACC_W-1:63];
  assign dfit = (&dhi) | ~(|dhi);
  assign av   = $signed(cof_r) >>> ADJ_SH;
  assign ahi  = av[ACC_W-1:31];
  assign afit = (&ahi) | ~(|ahi);
  assign cneg = cof_r[ACC_W-1];
  assign cmag = cneg ? (ACC_W'(0) - cof_r) : cof_r;
  assign num  = {cmag[COF_W-1:0], {ADJ_SH{1'b0}}};
  assign k_inc = k_r + 4'd1;

  assign div_start = (state_r == S_VAL) && (mode != MODE_ADJ) && !sing_r;
  assign emit_ok   = !out_valid_r || out_tready;

  mi4_div #(.NUM_W(NUM_W), .DEN_W(ACC_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (absd_r),
    .neg   (cneg ^ dneg_r),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            store_r[q_item.idx] <= q_item.value;
            if (q_item.go) begin
              pass2_r <= 1'b0;
              k_r     <= '0;
              tr_r    <= '0;
              tc_r    <= '0;
              det_r   <= '0;
              state_r <= S_CSTART;
            end
          end
        end
        S_CSTART: begin
          cof_r   <= '0;
          p_r     <= '0;
          state_r <= S_RA;
        end
        S_RA: begin
          rd_r    <= store_r[rd_addr];
          state_r <= S_RB;
        end
        S_RB: begin
          opa_r   <= rd_r;
          rd_r    <= store_r[rd_addr];
          state_r <= S_RC;
        end
        S_RC: begin
          x_r      <= {{(X_W-64){prod[63]}}, prod};
          rd_r     <= store_r[rd_addr];
          li_r     <= '0;
          last_r   <= 2'd1;
          to_det_r <= 1'b0;
          neg_r    <= perm_odd(p_r) ^ tr_r[0] ^ tc_r[0];
          state_r  <= S_MUL;
        end
        S_MUL: begin
          ml_r    <= ml_nxt;
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (to_det_r) begin
            det_r <= sum;
          end else begin
            cof_r <= sum;
          end
          if (li_r != last_r) begin
            li_r    <= li_r + 2'd1;
            state_r <= S_MUL;
          end else if (to_det_r) begin
            if (tc_r == 2'd3) begin
              state_r <= S_DFIN;
            end else begin
              tc_r    <= tc_r + 2'd1;
              state_r <= S_CSTART;
            end
          end else if (p_r == 3'd5) begin
            state_r <= S_CDONE;
          end else begin
            p_r     <= p_r + 3'd1;
            state_r <= S_RA;
          end
        end
        S_CDONE: begin
          if (pass2_r) begin
            state_r <= S_VAL;
          end else begin
            x_r      <= cof_r[X_W-1:0];
            rd_r     <= store_r[rd_addr];
            li_r     <= '0;
            last_r   <= 2'd3;
            to_det_r <= 1'b1;
            neg_r    <= 1'b0;
            state_r  <= S_MUL;
          end
        end
        S_DFIN: begin
          det_sat_r  <= !dfit;
          det_bits_r <= dfit ? dv[DET_W-1:0]
                             : {dv[ACC_W-1], {(DET_W-1){!dv[ACC_W-1]}}};
          sing_r     <= (det_r == '0);
          dneg_r     <= det_r[ACC_W-1];
          absd_r     <= det_r[ACC_W-1] ? (ACC_W'(0) - det_r) : det_r;
          if (mode[1]) begin
            val_r   <= '0;
            vsat_r  <= !dfit;
            state_r <= S_EMIT;
          end else begin
            pass2_r <= 1'b1;
            tr_r    <= '0;
            tc_r    <= '0;
            state_r <= S_CSTART;
          end
        end
        S_VAL: begin
          if (mode == MODE_ADJ) begin
            val_r   <= afit ? av[VAL_W-1:0]
                            : {av[ACC_W-1], {(VAL_W-1){!av[ACC_W-1]}}};
            vsat_r  <= det_sat_r | !afit;
            state_r <= S_EMIT;
          end else if (sing_r) begin
            val_r   <= '0;
            vsat_r  <= det_sat_r;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            val_r   <= div_quo;
            vsat_r  <= det_sat_r | div_sat;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {{(OUT_DATA_W-100){1'b0}}, det_bits_r, val_r, k_r[1:0], k_r[3:2]};
            out_user_r  <= {vsat_r, sing_r};
            out_last_r  <= mode[1] || (k_r == 4'd15);
            if (mode[1] || (k_r == 4'd15)) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_inc;
              tr_r    <= k_inc[1:0];
              tc_r    <= k_inc[3:2];
              state_r <= S_CSTART;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/matrix_inverse_4x4_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for matrix_inverse_4x4_unit: loads matrices word by word, runs all
// result modes and checks every result word against an exact cofactor predictor.
// Depends on mi4_pkg and the unit RTL.
module matrix_inverse_4x4_unit_tb;
  import mi4_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic [63:0] det;
    logic        singular;
    logic        sat;
    logic        last;
  } result_t;

  class inverse_board;
    logic [31:0] elems [16];
    logic [1:0]  mode;
    result_t     pending [$];
    int          errors;

    function new();
      foreach (elems[i]) elems[i] = '0;
      mode = MODE_INV;
      errors = 0;
    endfunction

    function wide_t ext(logic [31:0] b);
      return wide_t'(signed'(b));
    endfunction

    function wide_t cofactor(int r, int c);
      int    rs [3];
      int    cs [3];
      int    n;
      wide_t m [3][3];
      wide_t d;
      n = 0;
      for (int i = 0; i < 4; i++) if (i != r) begin rs[n] = i; n++; end
      n = 0;
      for (int i = 0; i < 4; i++) if (i != c) begin cs[n] = i; n++; end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) m[i][j] = ext(elems[rs[i] + 4 * cs[j]]);
      d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
        - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
        + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
      return ((r + c) % 2 == 1) ? -d : d;
    endfunction

    function void note_input(logic [3:0] idx, logic [31:0] val, logic go);
      wide_t   cof [4][4];
      wide_t   det, dv, a, num, q, lim, an, ad;
      wide_t   max32, min32;
      logic    det_sat, sing, neg;
      logic [63:0] det_bits;
      result_t e;
      elems[idx] = val;
      if (!go) return;
      max32 = wide_t'(64'sd2147483647);
      min32 = -wide_t'(64'sd2147483648);
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) cof[r][c] = cofactor(r, c);
      det = 0;
      for (int k = 0; k < 4; k++) det = det + cof[0][k] * ext(elems[4 * k]);
      sing = (det == 0);
      dv = det >>> 32;
      det_sat = 0;
      if (dv > wide_t'(64'sh7FFFFFFFFFFFFFFF)) begin
        det_sat = 1;
        det_bits = 64'h7FFFFFFFFFFFFFFF;
      end else if (dv < -wide_t'(65'sh08000000000000000)) begin
        det_sat = 1;
        det_bits = 64'h8000000000000000;
      end else det_bits = dv[63:0];
      if (mode >= MODE_DET) begin
        e = '{2'd0, 2'd0, 32'd0, det_bits, sing, det_sat, 1'b1};
        pending.push_back(e);
        return;
      end
      for (int k = 0; k < 16; k++) begin
        a = cof[k & 3][k >> 2];
        e.row = 2'(k >> 2);
        e.col = 2'(k & 3);
        e.det = det_bits;
        e.singular = sing;
        e.sat = det_sat;
        e.last = (k == 15);
        e.value = '0;
        if (mode == MODE_ADJ) begin
          a = a >>> 32;
          if (a > max32) begin
            e.sat = 1; e.value = 32'h7FFFFFFF;
          end else if (a < min32) begin
            e.sat = 1; e.value = 32'h80000000;
          end else e.value = a[31:0];
        end else if (!sing) begin
          num = a <<< 32;
          neg = (num < 0) != (det < 0);
          an = (num < 0) ? -num : num;
          ad = (det < 0) ? -det : det;
          q = an / ad;
          lim = neg ? -min32 : max32;
          if (q > lim) begin
            e.sat = 1; e.value = lim[31:0];
          end else e.value = neg ? -q[31:0] : q[31:0];
        end
        pending.push_back(e);
      end
    endfunction

    function void check(logic [1:0] row, logic [1:0] col, logic [31:0] value,
                        logic [63:0] det, logic sing, logic sat, logic last);
      result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word r%0d c%0d", row, col);
        return;
      end
      e = pending.pop_front();
      if (e.row !== row || e.col !== col || e.value !== value || e.det !== det ||
          e.singular !== sing || e.sat !== sat || e.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp r%0d c%0d v=%h d=%h s=%b x=%b l=%b | got r%0d c%0d v=%h d=%h s=%b x=%b l=%b",
                   e.row, e.col, e.value, e.det, e.singular, e.sat, e.last,
                   row, col, value, det, sing, sat, last);
      end
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en = 0;
  logic [1:0]            cfg_wr_data = '0;

  inverse_board board = new();
  bit calm = 0;

  matrix_inverse_4x4_unit u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_wr_en, .cfg_wr_data
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 22);
    if (rst_n && out_tvalid && out_tready)
      board.check(out_tdata[1:0], out_tdata[3:2], out_tdata[35:4], out_tdata[99:36],
                  out_tuser[0], out_tuser[1], out_tlast);
  end

  task automatic send_word(logic [3:0] idx, logic [31:0] val, logic go);
    bit taken;
    while (!calm && $urandom_range(99) < 22) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {4'd0, val, idx};
    in_tlast <= go;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    board.note_input(idx, val, go);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.mode = m;
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(9))
      6: return $urandom;
      7: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      8: return 32'd0;
      9: return $urandom_range(1) ? 32'h00010000 : 32'hFFFF0000;
      default: return 32'($signed($urandom_range(1048575)) - 524288);
    endcase
  endfunction

  task automatic random_words(int n);
    int sent;
    int order [16];
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) begin
        send_word(4'($urandom), $urandom, $urandom_range(19) == 0);
        sent++;
      end else begin
        foreach (order[i]) order[i] = i;
        order.shuffle();
        for (int i = 0; i < 16; i++)
          if (i == 15 || $urandom_range(3) != 0) begin
            send_word(4'(order[i]), (order[i] % 5 == 0 && $urandom_range(1)) ?
                      32'($signed($urandom_range(262143)) + 32'sh00040000) :
                      rand_elem(), i == 15);
            sent++;
          end
      end
    end
    send_word(4'($urandom), rand_elem(), 1);
  endtask

  task automatic diag(logic [31:0] a, logic [31:0] b);
    for (int i = 0; i < 16; i++)
      send_word(4'(i), (i % 5 == 0) ? ((i == 15) ? b : a) : 32'd0, i == 15);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_word(4'd3, 32'd0, 1);
    diag(32'h00010000, 32'h00010000);
    send_word(4'd4, 32'h7FFFFFFF, 1);
    set_mode(MODE_ADJ);
    diag(32'h7FFFFFFF, 32'h80000000);
    set_mode(MODE_INV);
    diag(32'h00000001, 32'hFFFFFFFF);
    calm = 1;
    random_words(60);
    calm = 0;
    random_words(50);
    set_mode(MODE_ADJ);
    random_words(70);
    set_mode(MODE_DET);
    random_words(60);
    set_mode(2'd3);
    random_words(30);
    set_mode(MODE_INV);
    random_words(30);
    drain();
    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
